>>> src/ped_pkg.sv
// shared types, constants and fixed-point helpers for the palette dither unit
`default_nettype none

package ped_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int PALETTE_ENTRIES = 16;
  localparam int FRAC_BITS       = 8;

  localparam int PIX_W   = 8;
  localparam int ERR_W   = FRAC_BITS + 10;
  localparam int EXT_W   = ERR_W + 3;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int SQ_W    = 2 * DIFF_W - 2;
  localparam int DIST_W  = SQ_W + 2;
  localparam int COL_W   = 10;
  localparam int WIDTH_W = 11;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int LBUF_W  = 3 * ERR_W;

  localparam logic CFG_LINE_WIDTH    = 1'b0;
  localparam logic CFG_PALETTE_COUNT = 1'b1;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  localparam logic signed [EXT_W-1:0] ERR_MAX = EXT_W'((1 << (ERR_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] ERR_MIN = -EXT_W'(1 << (ERR_W - 1));

  typedef logic signed [ERR_W-1:0] err_t;
  typedef err_t [2:0] err3_t;
  typedef logic [2:0][PIX_W-1:0] color_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } dist_tag_t;

  function automatic logic signed [EXT_W-1:0] ext_err(input err_t e);
    return {{(EXT_W - ERR_W){e[ERR_W-1]}}, e};
  endfunction

  function automatic logic signed [EXT_W-1:0] ext_pix(input logic [PIX_W-1:0] p);
    return {{(EXT_W - PIX_W - FRAC_BITS){1'b0}}, p, {FRAC_BITS{1'b0}}};
  endfunction

  function automatic err_t sat_err(input logic signed [EXT_W-1:0] x);
    err_t r;
    if (x > ERR_MAX) begin
      r = ERR_MAX[ERR_W-1:0];
    end else if (x < ERR_MIN) begin
      r = ERR_MIN[ERR_W-1:0];
    end else begin
      r = x[ERR_W-1:0];
    end
    return r;
  endfunction

  // (e * wgt) / 16 rounded toward minus infinity
  function automatic err_t share(input err_t e, input logic [2:0] wgt);
    logic signed [EXT_W:0] ex;
    logic signed [EXT_W:0] p;
    ex = {{(EXT_W + 1 - ERR_W){e[ERR_W-1]}}, e};
    p  = ex * $signed({{(EXT_W - 2){1'b0}}, wgt});
    return p[ERR_W+3:4];
  endfunction

endpackage

`default_nettype wire

>>> src/palette_error_diffusion_dither_unit.sv
// top level: palette nearest-match with floyd-steinberg error diffusion
//
// channel  direction  tdata (low bit up)                         tuser
// in_      slave      entry_index, blue, green, red, pad to 32   mode, frame_start
// out_     master     palette_index, blue, green, red, pad to 32 -
// cfg_     write      0 line_width, 1 palette_count              -
//
// a palette write is stored straight from idle; a pixel runs adjust, a search of the
// n effective palette entries (1 to 16), a wait and the error step, plus a second line
// buffer write on the last pixel of a row; the distance unit visits one palette entry per
// cycle through its two-stage pipeline. the line buffer takes one write per cycle.
// reset is synchronous; the line buffer and palette are not cleared.
// a held result stalls completion of the next pixel only.
`default_nettype none

module palette_error_diffusion_dither_unit
  import ped_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [31:0]        in_tdata,   // entry_index, blue, green, red
  input  wire logic [1:0]         in_tuser,   // mode, frame_start
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [31:0]             out_tdata,  // palette_index, blue, green, red
  input  wire logic               cfg_we,
  input  wire logic               cfg_addr,
  input  wire logic [WIDTH_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADJ  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;
  localparam logic [2:0] S_WR2  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [WIDTH_W-1:0] line_width_r;
  logic [CNT_W-1:0]   palette_count_r;
  color_t             pal_mem [PALETTE_ENTRIES];
  logic [LBUF_W-1:0]  lbuf_mem [MAX_WIDTH];
  logic [LBUF_W-1:0]  lbuf_rd_r;

  logic [COL_W-1:0]   column_count_r;
  logic               first_row_r;
  err3_t              right_r, pend_left_r, pend_here_r, new_left_r;
  color_t             pix_r;
  logic [COL_W-1:0]   c_r;
  logic               last_r;
  err3_t              v_r;
  logic [IDX_W-1:0]   k_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [IDX_W-1:0]   best_idx_r;
  color_t             best_col_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic               in_fire, pix_fire, fin_fire;
  logic [WIDTH_W-1:0] w_eff;
  logic [CNT_W-1:0]   n_eff;
  logic [IDX_W-1:0]   n_last;
  logic [COL_W-1:0]   col_sel, c_sel;
  logic [WIDTH_W-1:0] c_ext;
  logic               last_sel;
  color_t             in_col;
  err3_t              above, v_nxt, err, s1, s5, s7, left_wr, new_left;
  dist_tag_t          tag_in, tag_out;
  logic [DIST_W-1:0]  dist_out;
  color_t             col_out;
  logic               lbuf_we;
  logic [COL_W-1:0]   lbuf_wa;
  logic [LBUF_W-1:0]  lbuf_wd;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign pix_fire  = in_fire && (in_tuser[0] == MODE_PIXEL);
  assign fin_fire  = (state_r == S_ERR) && (!out_valid_r || out_tready);
  assign in_col    = {in_tdata[27:20], in_tdata[19:12], in_tdata[11:4]};

  always_comb begin
    if (line_width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (line_width_r > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = line_width_r;
    end
    if (palette_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (palette_count_r > CNT_W'(PALETTE_ENTRIES)) begin
      n_eff = CNT_W'(PALETTE_ENTRIES);
    end else begin
      n_eff = palette_count_r;
    end
    n_last  = IDX_W'(n_eff - CNT_W'(1));
    col_sel = in_tuser[1] ? '0 : column_count_r;
    if ({1'b0, col_sel} >= w_eff) begin
      c_ext = w_eff - WIDTH_W'(1);
    end else begin
      c_ext = {1'b0, col_sel};
    end
    c_sel    = c_ext[COL_W-1:0];
    last_sel = (c_ext + WIDTH_W'(1)) >= w_eff;
  end

  // adjusted pixel and error shares
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      above[ch]    = first_row_r ? '0 : err_t'(lbuf_rd_r[ch*ERR_W +: ERR_W]);
      v_nxt[ch]    = sat_err(ext_pix(pix_r[ch]) + ext_err(above[ch]) + ext_err(right_r[ch]));
      err[ch]      = sat_err(ext_err(v_r[ch]) - ext_pix(best_col_r[ch]));
      s1[ch]       = share(err[ch], 3'd1);
      s5[ch]       = share(err[ch], 3'd5);
      s7[ch]       = share(err[ch], 3'd7);
      left_wr[ch]  = sat_err(ext_err(pend_left_r[ch]) + ext_err(share(err[ch], 3'd3)));
      new_left[ch] = sat_err(ext_err(pend_here_r[ch]) + ext_err(s5[ch]));
    end
  end

  assign tag_in = '{valid: (state_r == S_SRCH), last: (k_r == n_last), idx: k_r};

  ped_dist_unit u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (v_r),
    .col_i  (pal_mem[k_r]),
    .tag_i  (tag_in),
    .dist_o (dist_out),
    .col_o  (col_out),
    .tag_o  (tag_out)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (pix_fire) state_nxt = S_ADJ;
      S_ADJ:  state_nxt = S_SRCH;
      S_SRCH: if (k_r == n_last) state_nxt = S_WAIT;
      S_WAIT: if (tag_out.valid && tag_out.last) state_nxt = S_ERR;
      S_ERR:  if (fin_fire) state_nxt = last_r ? S_WR2 : S_IDLE;
      S_WR2:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      line_width_r    <= WIDTH_W'(640);
      palette_count_r <= CNT_W'(4);
      column_count_r  <= '0;
      first_row_r     <= 1'b1;
      right_r         <= '0;
      pend_left_r     <= '0;
      pend_here_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LINE_WIDTH:    line_width_r    <= cfg_wdata;
          CFG_PALETTE_COUNT: palette_count_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (pix_fire && in_tuser[1]) begin
        first_row_r <= 1'b1;
        right_r     <= '0;
        pend_left_r <= '0;
        pend_here_r <= '0;
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_fire) begin
        if (last_r) begin
          column_count_r <= '0;
          first_row_r    <= 1'b0;
          right_r        <= '0;
          pend_left_r    <= '0;
          pend_here_r    <= '0;
        end else begin
          column_count_r <= c_r + COL_W'(1);
          right_r        <= s7;
          pend_left_r    <= new_left;
          pend_here_r    <= s1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser[0] == MODE_PALETTE)) begin
      pal_mem[in_tdata[IDX_W-1:0]] <= in_col;
    end
    if (pix_fire) begin
      pix_r  <= in_col;
      c_r    <= c_sel;
      last_r <= last_sel;
    end
    if (state_r == S_ADJ) begin
      v_r <= v_nxt;
      k_r <= '0;
    end else if (state_r == S_SRCH) begin
      k_r <= k_r + IDX_W'(1);
    end
    if (tag_out.valid && ((tag_out.idx == '0) || (dist_out < best_dist_r))) begin
      best_dist_r <= dist_out;
      best_idx_r  <= tag_out.idx;
      best_col_r  <= col_out;
    end
    if (fin_fire) begin
      new_left_r <= new_left;
      out_data_r <= {4'b0000, best_col_r[2], best_col_r[1], best_col_r[0], best_idx_r};
    end
  end

  // line buffer of errors for the next row
  always_comb begin
    lbuf_we = (fin_fire && (c_r != '0)) || (state_r == S_WR2);
    lbuf_wa = (state_r == S_WR2) ? c_r : c_r - COL_W'(1);
    lbuf_wd = (state_r == S_WR2) ? new_left_r : left_wr;
  end

  always_ff @(posedge clk) begin
    if (lbuf_we) begin
      lbuf_mem[lbuf_wa] <= lbuf_wd;
    end
    if (pix_fire) begin
      lbuf_rd_r <= lbuf_mem[c_sel];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_no_lbuf_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !lbuf_we)
    else $error("line buffer written while idle");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ({1'b0, c_r} < w_eff))
    else $error("column outside row");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR) |-> ({1'b0, best_idx_r} < n_eff))
    else $error("chosen entry outside palette count");

  a_pixel_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pix_fire |=> (state_r == S_ADJ))
    else $error("pixel transaction did not start adjust");
`endif

endmodule

`default_nettype wire

>>> src/ped_dist_unit.sv
// shared squared-distance unit: three channel squares, then their sum
`default_nettype none

module ped_dist_unit
  import ped_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire err3_t             v_i,
  input  wire color_t            col_i,
  input  wire dist_tag_t         tag_i,
  output logic [DIST_W-1:0]      dist_o,
  output color_t                 col_o,
  output dist_tag_t              tag_o
);

  logic [2:0][SQ_W-1:0] sq_r;
  color_t               sq_col_r;
  dist_tag_t            sq_tag_r;
  logic [DIST_W-1:0]    dist_r;
  color_t               dist_col_r;
  dist_tag_t            dist_tag_r;

  logic signed [DIFF_W-1:0]   d [3];
  logic signed [2*DIFF_W-1:0] p [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      d[ch] = $signed({v_i[ch][ERR_W-1], v_i[ch]}) -
              $signed({{(DIFF_W - PIX_W - FRAC_BITS){1'b0}}, col_i[ch], {FRAC_BITS{1'b0}}});
      p[ch] = d[ch] * d[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_tag_r   <= '0;
      dist_tag_r <= '0;
    end else begin
      sq_tag_r   <= tag_i;
      dist_tag_r <= sq_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      sq_r[ch] <= p[ch][SQ_W-1:0];
    end
    sq_col_r   <= col_i;
    dist_r     <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
    dist_col_r <= sq_col_r;
  end

  assign dist_o = dist_r;
  assign col_o  = dist_col_r;
  assign tag_o  = dist_tag_r;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// self-checking testbench for the palette dither unit: predicts every pick and compares results
`default_nettype none

module tb_top;
  import ped_pkg::*;

  localparam longint FIX_ONE = 1 << FRAC_BITS;
  localparam longint ERR_HI = (1 << (ERR_W - 1)) - 1;
  localparam longint ERR_LO = -(1 << (ERR_W - 1));
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS = 1120;

  typedef struct packed {
    color_t           color;
    logic [IDX_W-1:0] index;
  } dither_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata = '0;   // entry_index, blue, green, red
  logic [1:0]         in_tuser = '0;   // mode, frame_start
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;       // palette_index, blue, green, red
  logic               cfg_we = 1'b0;
  logic               cfg_addr = CFG_LINE_WIDTH;
  logic [WIDTH_W-1:0] cfg_wdata = '0;

  palette_error_diffusion_dither_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [WIDTH_W-1:0] width_reg = 11'd640;
  logic [CNT_W-1:0]   count_reg = 5'd4;
  color_t             pal_colors [PALETTE_ENTRIES];
  err_t               row_below_err [MAX_WIDTH][3];
  err_t               carry_right [3];
  err_t               below_left_acc [3];
  err_t               below_here_acc [3];
  int                 col_pos = 0;
  bit                 top_row = 1'b1;

  dither_result_t     expected_picks [$];
  int                 errors = 0;
  int                 results_checked = 0;
  int                 pixel_items = 0;
  int                 palette_items = 0;
  int                 phases = 0;
  bit                 steady_flow = 1'b0;

  function automatic err_t clamp_err(input longint x);
    if (x > ERR_HI) return err_t'(ERR_HI);
    if (x < ERR_LO) return err_t'(ERR_LO);
    return err_t'(x);
  endfunction

  // floor(e * wgt / 16)
  function automatic err_t weighted_part(input err_t e, input int wgt);
    int p;
    p = int'(e) * wgt;
    return err_t'(p >>> 4);
  endfunction

  function automatic int span_of(input logic [WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return int'(w);
  endfunction

  function automatic void dither_pixel(input bit fresh_frame, input color_t px);
    int w, n, c, best;
    longint best_dist, sq_sum, d;
    bit row_end;
    err_t adj [3];
    err_t qerr, left_sum;
    dither_result_t pick;
    if (fresh_frame) begin
      col_pos = 0;
      top_row = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        carry_right[ch] = '0;
        below_left_acc[ch] = '0;
        below_here_acc[ch] = '0;
      end
    end
    w = span_of(width_reg);
    n = (count_reg == 0) ? 1 : ((count_reg > PALETTE_ENTRIES) ? PALETTE_ENTRIES : int'(count_reg));
    c = (col_pos >= w) ? w - 1 : col_pos;
    row_end = (c + 1 >= w);
    for (int ch = 0; ch < 3; ch++) begin
      adj[ch] = clamp_err(longint'(px[ch]) * FIX_ONE
                          + (top_row ? 64'sd0 : longint'(row_below_err[c][ch]))
                          + longint'(carry_right[ch]));
    end
    best = 0;
    best_dist = 0;
    for (int i = 0; i < n; i++) begin
      sq_sum = 0;
      for (int ch = 0; ch < 3; ch++) begin
        d = longint'(adj[ch]) - longint'(pal_colors[i][ch]) * FIX_ONE;
        sq_sum += d * d;
      end
      if (i == 0 || sq_sum < best_dist) begin
        best_dist = sq_sum;
        best = i;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      qerr = clamp_err(longint'(adj[ch]) - longint'(pal_colors[best][ch]) * FIX_ONE);
      if (c > 0) begin
        row_below_err[c-1][ch] = clamp_err(longint'(below_left_acc[ch])
                                           + longint'(weighted_part(qerr, 3)));
      end
      left_sum = clamp_err(longint'(below_here_acc[ch]) + longint'(weighted_part(qerr, 5)));
      if (row_end) begin
        row_below_err[c][ch] = left_sum;
        below_left_acc[ch] = '0;
        below_here_acc[ch] = '0;
        carry_right[ch] = '0;
      end else begin
        below_left_acc[ch] = left_sum;
        below_here_acc[ch] = weighted_part(qerr, 1);
        carry_right[ch] = weighted_part(qerr, 7);
      end
    end
    if (row_end) begin
      col_pos = 0;
      top_row = 1'b0;
    end else begin
      col_pos = c + 1;
    end
    pick.color = pal_colors[best];
    pick.index = best[IDX_W-1:0];
    expected_picks.insert(expected_picks.size(), pick);
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic color_t rand_color();
    color_t c;
    int r;
    for (int ch = 0; ch < 3; ch++) begin
      r = $urandom_range(0, 9);
      c[ch] = (r == 0) ? 8'd0 : ((r == 1) ? 8'd255 : 8'($urandom_range(0, 255)));
    end
    return c;
  endfunction

  task automatic send_item(input logic mode, input logic fs, input logic [IDX_W-1:0] idx,
                           input color_t color);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, color, idx};
    in_tuser <= {fs, mode};
    do @(posedge clk); while (in_tready !== 1'b1);
    if (mode == MODE_PALETTE) begin
      pal_colors[idx] = color;
      palette_items++;
    end else begin
      dither_pixel(fs, color);
      pixel_items++;
    end
  endtask

  task automatic write_config(input logic [WIDTH_W-1:0] width, input logic [WIDTH_W-1:0] count);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_LINE_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    width_reg = width;
    cfg_addr <= CFG_PALETTE_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    count_reg = count[CNT_W-1:0];
    cfg_we <= 1'b0;
  endtask

  // drain all pending picks, then give a trailing palette write time to finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_palette_load();
    color_t c;
    write_config(11'd2, 11'd16);
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      unique case (i)
        0, 2: c = '0;
        1: c = '1;
        3: c = {8'd0, 8'd0, 8'd255};
        default: c = rand_color();
      endcase
      // frame start on a palette write must be ignored
      send_item(MODE_PALETTE, i == 5, IDX_W'(i), c);
    end
    settle();
  endtask

  task automatic test_nearest_and_ties();
    write_config(11'd2, 11'd16);
    // black matches entries 0 and 2 equally, lower index wins
    send_item(MODE_PIXEL, 1'b1, 4'hf, '0);
    send_item(MODE_PIXEL, 1'b0, 4'h0, '1);
    send_item(MODE_PIXEL, 1'b0, 4'h5, {8'd200, 8'd64, 8'd128});
    send_item(MODE_PIXEL, 1'b0, 4'ha, rand_color());
    settle();
  endtask

  task automatic test_config_extremes();
    // zero width acts as one, zero count as one
    write_config(11'd0, 11'd0);
    send_item(MODE_PIXEL, 1'b1, 4'h3, '1);
    send_item(MODE_PIXEL, 1'b0, 4'hc, '1);
    settle();
    // oversized width and count clamp to the maximum
    write_config(11'd2047, 11'd31);
    send_item(MODE_PIXEL, 1'b1, 4'h0, rand_color());
    send_item(MODE_PIXEL, 1'b0, 4'h0, rand_color());
    settle();
    // shrink mid-row: column clamps and that pixel closes the row
    write_config(11'd2, 11'd17);
    send_item(MODE_PIXEL, 1'b0, 4'h0, rand_color());
    send_item(MODE_PIXEL, 1'b0, 4'h0, rand_color());
    settle();
  endtask

  task automatic test_random_frames(input int item_goal);
    int sent, n, r, old_span;
    logic [WIDTH_W-1:0] w, cnt;
    bit flat, first_fs;
    color_t tint;
    sent = 0;
    while (sent < item_goal) begin
      old_span = span_of(width_reg);
      r = $urandom_range(0, 99);
      if (r < 6) w = WIDTH_W'($urandom_range(0, 1));
      else if (r < 10) w = WIDTH_W'($urandom_range(1000, 2047));
      else w = WIDTH_W'($urandom_range(2, 12));
      r = $urandom_range(0, 99);
      if (r < 10) cnt = '0;
      else if (r < 20) cnt = WIDTH_W'($urandom_range(17, 31));
      else cnt = WIDTH_W'($urandom_range(1, 16));
      // flat extreme colour with a tiny palette drives the error into saturation
      flat = ($urandom_range(0, 6) == 0);
      for (int ch = 0; ch < 3; ch++) tint[ch] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      if (flat) begin
        w = WIDTH_W'($urandom_range(3, 8));
        cnt = WIDTH_W'($urandom_range(0, 2));
      end
      steady_flow = ($urandom_range(0, 4) == 0);
      write_config(w, cnt);
      // a wider row needs a fresh frame so no stale line buffer entry is read
      first_fs = (span_of(w) > old_span) || ($urandom_range(0, 2) == 0);
      n = $urandom_range(10, 60);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (k > 0 && r < 6) begin
          send_item(MODE_PALETTE, 1'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, PALETTE_ENTRIES - 1)),
                    (r < 2) ? pal_colors[$urandom_range(0, PALETTE_ENTRIES - 1)] : rand_color());
        end else begin
          send_item(MODE_PIXEL, (k == 0) ? first_fs : (r > 96),
                    IDX_W'($urandom_range(0, PALETTE_ENTRIES - 1)),
                    flat ? tint : rand_color());
        end
      end
      sent += n;
      phases++;
      settle();
      steady_flow = 1'b0;
    end
  endtask

  // result sink pacing
  initial begin : sink_pacing
    int n;
    @(posedge clk);
    forever begin
      n = gap_cycles();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    dither_result_t got, want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = dither_result_t'(out_tdata[27:0]);
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected transaction, got index %0d color %h", $time,
                 got.index, got.color);
        errors++;
      end else begin
        want = expected_picks.pop_front();
        results_checked++;
        if (got.index !== want.index) begin
          $display("%0t: palette_index mismatch, expected %0d actual %0d", $time,
                   want.index, got.index);
          errors++;
        end
        for (int ch = 0; ch < 3; ch++) begin
          if (got.color[ch] !== want.color[ch]) begin
            $display("%0t: channel %0d (0 blue, 1 green, 2 red) mismatch, expected %0d actual %0d",
                     $time, ch, want.color[ch], got.color[ch]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_load();
    test_nearest_and_ties();
    test_config_extremes();
    test_random_frames(RANDOM_ITEMS);
    settle();
    $display("run covered %0d pixels and %0d palette writes over %0d random config phases",
             pixel_items, palette_items, phases);
    $display("%0d result transactions checked, %0d mismatches", results_checked, errors);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_picks.size());
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
